// File: hw/rtl/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants of the heightmap barycentric sampler
// grid geometry, fixed-point widths, register indexes and the command record
// that travels from the front end to the back end
// ----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

    // grid geometry (power-of-two sides, banked by x and z parity)
    localparam int MAX_GRID_W  = 64;
    localparam int MAX_GRID_H  = 64;
    localparam int FRAC_BITS   = 8;
    localparam int XW          = $clog2(MAX_GRID_W);
    localparam int ZW          = $clog2(MAX_GRID_H);
    localparam int STORE_DEPTH = MAX_GRID_W * MAX_GRID_H;
    localparam int NUM_BANKS   = 4;
    localparam int BANK_AW     = (XW - 1) + (ZW - 1);
    localparam int BANK_DEPTH  = 1 << BANK_AW;

    // field widths
    localparam int IDX_W    = 12;
    localparam int SAMPLE_W = 16;
    localparam int COORD_W  = 20;
    localparam int TX_W     = COORD_W + 1;
    localparam int GX_W     = TX_W - 1 - FRAC_BITS;
    localparam int DIM_W    = 7;
    localparam int SCALE_W  = 16;
    localparam int HGT_W    = 16;
    localparam int WGT_W    = FRAC_BITS + 1;
    localparam int PROD_W   = WGT_W + 1 + HGT_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // stream packing
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;

    // command queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

    // register reset values
    localparam logic [DIM_W-1:0]   GRID_W_RST = 7'd64;
    localparam logic [DIM_W-1:0]   GRID_H_RST = 7'd64;
    localparam logic [SCALE_W-1:0] SCALE_RST  = 16'd6554;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Z      = 3'd1,
        CFG_GRID_WIDTH    = 3'd2,
        CFG_GRID_HEIGHT   = 3'd3,
        CFG_HEIGHT_SCALE  = 3'd4,
        CFG_HEIGHT_OFFSET = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_z;
        logic [DIM_W-1:0]          grid_width;
        logic [DIM_W-1:0]          grid_height;
        logic [SCALE_W-1:0]        height_scale;
        logic signed [HGT_W-1:0]   height_offset;
    } t_cfg;

    // one classified item; x/z are the cell for a query or the load address
    typedef struct packed {
        logic                is_query;
        logic                in_range;
        logic                upper;
        logic                wr_ok;
        logic [XW-1:0]       x;
        logic [ZW-1:0]       z;
        logic [WGT_W-1:0]    wa;
        logic [WGT_W-1:0]    wb;
        logic [WGT_W-1:0]    wc;
        logic [SAMPLE_W-1:0] scaled;
    } t_cmd;

endpackage

`default_nettype wire

// File: hw/rtl/hbs_front.sv
// ----------------------------------------------------------------------------
// hbs_front: item classifier
// decodes an incoming transaction into a command: loads get their scaled
// sample and address, queries get their cell, range flag, triangle and weights
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_front
    import hbs_pkg::*;
(
    input  wire t_cfg                  i_cfg,
    input  wire                        i_opcode,
    input  wire [IDX_W-1:0]            i_cell_index,
    input  wire [SAMPLE_W-1:0]         i_sample,
    input  wire signed [COORD_W-1:0]   i_query_x,
    input  wire signed [COORD_W-1:0]   i_query_z,
    output t_cmd                       o_cmd
);

    localparam logic [WGT_W-1:0] ONE = WGT_W'(1 << FRAC_BITS);

    logic signed [TX_W-1:0] tx;
    logic signed [TX_W-1:0] tz;
    logic [GX_W-1:0]        gx;
    logic [GX_W-1:0]        gz;
    logic [DIM_W-1:0]       cx;
    logic [DIM_W-1:0]       cz;
    logic [WGT_W-1:0]       u;
    logic [WGT_W-1:0]       v;
    logic [WGT_W-1:0]       uv;
    logic                   upper;
    logic [2*SAMPLE_W:0]    prod;

    // number of usable cells along one side, clamped to the store
    function automatic logic [DIM_W-1:0] cells_along(input logic [DIM_W-1:0] n,
                                                     input logic [DIM_W-1:0] maxn);
        logic [DIM_W-1:0] m;
        m = (n > maxn) ? maxn : n;
        return (m < DIM_W'(2)) ? '0 : m - DIM_W'(1);
    endfunction

    // origin-relative coordinates and cell split
    always_comb begin
        tx = TX_W'(i_query_x) - TX_W'(i_cfg.origin_x);
        tz = TX_W'(i_query_z) - TX_W'(i_cfg.origin_z);
        gx = tx[TX_W-2:FRAC_BITS];
        gz = tz[TX_W-2:FRAC_BITS];
        u  = {1'b0, tx[FRAC_BITS-1:0]};
        v  = {1'b0, tz[FRAC_BITS-1:0]};
        uv = u + v;
        upper = uv > ONE;
        cx = cells_along(i_cfg.grid_width, DIM_W'(MAX_GRID_W));
        cz = cells_along(i_cfg.grid_height, DIM_W'(MAX_GRID_H));
    end

    // scaled load sample, rounded half up to q8.8
    assign prod = (2*SAMPLE_W+1)'(i_sample) * (2*SAMPLE_W+1)'(i_cfg.height_scale)
                + (2*SAMPLE_W+1)'(1 << (SAMPLE_W - 1));

    // command build
    always_comb begin
        o_cmd = '0;
        if (t_opcode'(i_opcode) == OP_QUERY) begin
            o_cmd.is_query = 1'b1;
            o_cmd.in_range = !tx[TX_W-1] && !tz[TX_W-1]
                           && (gx < GX_W'(cx)) && (gz < GX_W'(cz));
            o_cmd.upper    = upper;
            o_cmd.x        = gx[XW-1:0];
            o_cmd.z        = gz[ZW-1:0];
            if (upper) begin
                o_cmd.wa = uv - ONE;
                o_cmd.wb = ONE - v;
                o_cmd.wc = ONE - u;
            end else begin
                o_cmd.wa = ONE - uv;
                o_cmd.wb = u;
                o_cmd.wc = v;
            end
        end else begin
            o_cmd.wr_ok  = {1'b0, i_cell_index} < (IDX_W+1)'(STORE_DEPTH);
            o_cmd.x      = i_cell_index[XW-1:0];
            o_cmd.z      = i_cell_index[XW+ZW-1:XW];
            o_cmd.scaled = prod[2*SAMPLE_W-1:SAMPLE_W];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hbs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// hbs_cmd_fifo: command queue
// short register queue between the classifier and the execution pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_cmd_fifo
    import hbs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  wire t_cmd   i_data,
    output logic        o_full,
    input  wire         i_pop,
    output logic        o_valid,
    output t_cmd        o_data
);

    t_cmd                 r_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_PW:0]     r_count, n_count;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + FIFO_PW'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + FIFO_PW'(1) : r_rd_ptr;
        n_count  = r_count + (FIFO_PW+1)'(i_push) - (FIFO_PW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = r_count == (FIFO_PW+1)'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// File: hw/rtl/hbs_back.sv
// ----------------------------------------------------------------------------
// hbs_back: execution pipeline
// four parity banks of the height store, corner fetch, weighted blend,
// rounding and the output register; the whole pipeline moves together
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_back
    import hbs_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire signed [HGT_W-1:0]   i_height_offset,
    input  wire                      i_head_valid,
    input  wire t_cmd                i_head,
    output logic                     o_pop,
    output logic                     o_m_tvalid,
    input  wire                      i_m_tready,
    output logic signed [HGT_W-1:0]  o_m_height,
    output logic                     o_m_in_range
);

    localparam int SUM_W = SAMPLE_W + 2;

    logic                      advance;
    logic                      pop;
    logic                      wr_en;
    logic [1:0]                wr_bank;
    logic [BANK_AW-1:0]        wr_addr;
    logic signed [SUM_W-1:0]   wr_sum;
    logic [HGT_W-1:0]          wr_data;
    logic signed [HGT_W-1:0]   r_rd [NUM_BANKS];

    logic                      r_s1_valid;
    t_cmd                      r_s1;
    logic [1:0]                i00, i10, i01, i11;
    logic signed [HGT_W-1:0]   h_a, h_b, h_c;
    logic signed [PROD_W-1:0]  p_a, p_b, p_c;

    logic                      r_s2_valid;
    logic                      r_s2_query;
    logic                      r_s2_in_range;
    logic signed [PROD_W-1:0]  r_pa, r_pb, r_pc;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-FRAC_BITS-1:0] rounded;
    logic signed [HGT_W-1:0]   blended;

    logic                      r_out_valid;
    logic signed [HGT_W-1:0]   r_out_height;
    logic                      r_out_in_range;

    // pipeline moves when the output register is free or being taken
    assign advance = !r_out_valid || i_m_tready;
    assign pop     = i_head_valid && advance;
    assign o_pop   = pop;

    // load write: offset and saturate
    always_comb begin
        wr_sum  = SUM_W'(i_head.scaled) + SUM_W'(i_height_offset);
        if (wr_sum > SUM_W'(32767)) begin
            wr_data = 16'h7fff;
        end else if (wr_sum < -SUM_W'(32768)) begin
            wr_data = 16'h8000;
        end else begin
            wr_data = wr_sum[HGT_W-1:0];
        end
        wr_en   = pop && !i_head.is_query && i_head.wr_ok;
        wr_bank = {i_head.z[0], i_head.x[0]};
        wr_addr = {i_head.z[ZW-1:1], i_head.x[XW-1:1]};
    end

    // parity banks, each read at the corner that falls on it
    for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
        localparam logic BX = 1'(gb % 2);
        localparam logic BZ = 1'(gb / 2);

        logic [HGT_W-1:0]   r_mem [BANK_DEPTH];
        logic [XW-1:0]      col;
        logic [ZW-1:0]      row;
        logic [BANK_AW-1:0] rd_addr;

        always_comb begin
            col     = (i_head.x[0] == BX) ? i_head.x : i_head.x + XW'(1);
            row     = (i_head.z[0] == BZ) ? i_head.z : i_head.z + ZW'(1);
            rd_addr = {row[ZW-1:1], col[XW-1:1]};
        end

        always_ff @(posedge i_clk) begin
            if (wr_en && (wr_bank == 2'(gb))) begin
                r_mem[wr_addr] <= wr_data;
            end
            if (advance) begin
                r_rd[gb] <= r_mem[rd_addr];
            end
        end
    end

    // stage 1: command alongside the bank read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1 <= i_head;
        end
    end

    // corner pick and weight products
    always_comb begin
        i00 = {r_s1.z[0], r_s1.x[0]};
        i10 = {r_s1.z[0], ~r_s1.x[0]};
        i01 = {~r_s1.z[0], r_s1.x[0]};
        i11 = {~r_s1.z[0], ~r_s1.x[0]};
        h_a = r_s1.upper ? r_rd[i11] : r_rd[i00];
        h_b = r_rd[i10];
        h_c = r_rd[i01];
        p_a = $signed({1'b0, r_s1.wa}) * h_a;
        p_b = $signed({1'b0, r_s1.wb}) * h_b;
        p_c = $signed({1'b0, r_s1.wc}) * h_c;
    end

    // stage 2: registered products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_query    <= r_s1.is_query;
            r_s2_in_range <= r_s1.in_range;
            r_pa          <= p_a;
            r_pb          <= p_b;
            r_pc          <= p_c;
        end
    end

    // sum, round half up, saturate
    always_comb begin
        acc = ACC_W'(r_pa) + ACC_W'(r_pb) + ACC_W'(r_pc)
            + ACC_W'(1 << (FRAC_BITS - 1));
        rounded = acc[ACC_W-1:FRAC_BITS];
        if (rounded > (ACC_W-FRAC_BITS)'(32767)) begin
            blended = 16'sh7fff;
        end else if (rounded < -(ACC_W-FRAC_BITS)'(32768)) begin
            blended = -16'sh8000;
        end else begin
            blended = rounded[HGT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s2_valid && r_s2_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_height   <= r_s2_in_range ? blended : '0;
            r_out_in_range <= r_s2_in_range;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_height   = r_out_height;
    assign o_m_in_range = r_out_in_range;

endmodule

`default_nettype wire

// File: hw/rtl/heightmap_barycentric_sampler_top.sv
// ----------------------------------------------------------------------------
// heightmap_barycentric_sampler_top: terrain height sampler
// holds a 64 x 64 height grid and returns triangle-interpolated heights
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while the result side keeps up: a load
// (tuser 0) writes one scaled grid sample and returns nothing, a query
// (tuser 1) returns one height. With an empty queue the query leaves the
// queue into stage 1 with the bank read, then passes stage 2 and the output
// register, which raises m_axis_tvalid. The rate is set by the store being
// split into four banks by x and z parity, so all three corners of a triangle
// are read together, and a load writes one bank in its slot. A four-entry
// command queue keeps the input side taking items while the result register
// is stalled. The store has no reset and needs no clearing; a query must only
// touch cells that were loaded. The user must write configuration through its
// own channel only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_barycentric_sampler_top
    import hbs_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // slave stream
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    // [11:0] cell_index, [27:12] sample, [47:28] query_x, [67:48] query_z
    input  wire [IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] opcode
    input  wire [0:0]               s_axis_tuser,
    // master stream
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    // [15:0] height
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] in_range
    output logic [0:0]              m_axis_tuser,
    // configuration write channel
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [CFG_DATA_W-1:0]    i_cfg_data
);

    t_cfg                    r_cfg, n_cfg;
    t_cmd                    front_cmd;
    t_cmd                    head_cmd;
    logic                    fifo_full;
    logic                    head_valid;
    logic                    head_pop;
    logic                    in_push;
    logic signed [HGT_W-1:0] out_height;
    logic                    out_in_range;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORIGIN_X:      n_cfg.origin_x      = i_cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Z:      n_cfg.origin_z      = i_cfg_data[COORD_W-1:0];
                CFG_GRID_WIDTH:    n_cfg.grid_width    = i_cfg_data[DIM_W-1:0];
                CFG_GRID_HEIGHT:   n_cfg.grid_height   = i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT_SCALE:  n_cfg.height_scale  = i_cfg_data[SCALE_W-1:0];
                CFG_HEIGHT_OFFSET: n_cfg.height_offset = i_cfg_data[HGT_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= '0;
            r_cfg.origin_z      <= '0;
            r_cfg.grid_width    <= GRID_W_RST;
            r_cfg.grid_height   <= GRID_H_RST;
            r_cfg.height_scale  <= SCALE_RST;
            r_cfg.height_offset <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // input transaction goes straight into the queue
    assign s_axis_tready = !fifo_full;
    assign in_push       = s_axis_tvalid && !fifo_full;

    hbs_front u_front (
        .i_cfg        (r_cfg),
        .i_opcode     (s_axis_tuser[0]),
        .i_cell_index (s_axis_tdata[11:0]),
        .i_sample     (s_axis_tdata[27:12]),
        .i_query_x    (s_axis_tdata[47:28]),
        .i_query_z    (s_axis_tdata[67:48]),
        .o_cmd        (front_cmd)
    );

    hbs_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_push),
        .i_data  (front_cmd),
        .o_full  (fifo_full),
        .i_pop   (head_pop),
        .o_valid (head_valid),
        .o_data  (head_cmd)
    );

    hbs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_height_offset (r_cfg.height_offset),
        .i_head_valid    (head_valid),
        .i_head          (head_cmd),
        .o_pop           (head_pop),
        .o_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .o_m_height      (out_height),
        .o_m_in_range    (out_in_range)
    );

    // result transaction
    assign m_axis_tdata = out_height;
    assign m_axis_tuser = out_in_range;

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the heightmap barycentric sampler
// loads and queries go in on the slave stream, heights come back on the master
// stream; a shadow grid and register copy work out every height, and each
// result is compared field by field, in order, with random idling on both
// sides, one long result-side hold and several register settings
// ----------------------------------------------------------------------------
module tb;
    import hbs_pkg::*;

    localparam int UNIT         = 1 << FRAC_BITS;
    localparam int HGT_MAX      = 2 ** (HGT_W - 1) - 1;
    localparam int HGT_MIN      = -(2 ** (HGT_W - 1));
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;

    // register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        t_opcode                   op;
        logic [IDX_W-1:0]          cell_index;
        logic [SAMPLE_W-1:0]       sample;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qz;
    } t_grid_item;

    typedef struct packed {
        logic signed [HGT_W-1:0] height;
        logic                    in_range;
    } t_height_answer;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // slave stream
    logic                   s_tvalid = 1'b0;
    wire                    s_axis_tready;
    wire [IN_TDATA_W-1:0]   s_tdata;
    wire [0:0]              s_tuser;
    t_grid_item             offered = '0;

    // master stream
    wire                    m_axis_tvalid;
    logic                   m_tready = 1'b0;
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;
    wire [0:0]              m_axis_tuser;

    // configuration channel
    logic                   cfg_valid = 1'b0;
    wire                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // shadow registers and height grid
    logic signed [COORD_W-1:0] org_x    = '0;
    logic signed [COORD_W-1:0] org_z    = '0;
    logic [DIM_W-1:0]          grid_w   = GRID_W_RST;
    logic [DIM_W-1:0]          grid_h   = GRID_H_RST;
    logic [SCALE_W-1:0]        gain     = SCALE_RST;
    logic signed [HGT_W-1:0]   base     = '0;
    logic signed [HGT_W-1:0]   shadow_heights [STORE_DEPTH];

    // stimulus bookkeeping
    bit             cell_loaded [STORE_DEPTH];
    t_grid_item     pending_items [$];
    t_height_answer pending_answers [$];
    int             queued_count = 0;
    bit             send_idle_on = 1'b1;
    bit             recv_idle_on = 1'b1;
    int             send_gap     = 0;
    int             recv_gap     = 0;
    int             hold_left    = 0;
    bit             hold_done    = 1'b0;
    int             results_seen = 0;
    int             error_count  = 0;
    int             cycle_count  = 0;

    assign s_tdata = {{(IN_TDATA_W - IDX_W - SAMPLE_W - 2 * COORD_W){1'b0}},
                      offered.qz, offered.qx, offered.sample, offered.cell_index};
    assign s_tuser = offered.op;

    heightmap_barycentric_sampler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // height prediction
    // ------------------------------------------------------------------------
    function automatic logic signed [HGT_W-1:0] sat16(input int v);
        if (v > HGT_MAX) return HGT_W'(HGT_MAX);
        if (v < HGT_MIN) return HGT_W'(HGT_MIN);
        return v[HGT_W-1:0];
    endfunction

    // cells along one axis once the size is clamped; below two samples none
    function automatic int cells_in_use(input logic [DIM_W-1:0] n, input int limit);
        int c;
        c = (int'(n) > limit) ? limit : int'(n);
        return (c < 2) ? 0 : c - 1;
    endfunction

    function automatic int stored_at(input int x, input int z);
        return int'(shadow_heights[z * MAX_GRID_W + x]);
    endfunction

    // maps a world point to a cell and fraction; false when outside the grid
    function automatic bit locate(input logic signed [COORD_W-1:0] qx,
                                  input logic signed [COORD_W-1:0] qz,
                                  output logic [XW-1:0] x, output logic [ZW-1:0] z,
                                  output logic [FRAC_BITS-1:0] u,
                                  output logic [FRAC_BITS-1:0] v);
        logic signed [TX_W-1:0] tx;
        logic signed [TX_W-1:0] tz;
        int gx;
        int gz;
        x = '0;
        z = '0;
        u = '0;
        v = '0;
        tx = qx - org_x;
        tz = qz - org_z;
        if (tx < 0 || tz < 0) return 1'b0;
        gx = int'(tx >>> FRAC_BITS);
        gz = int'(tz >>> FRAC_BITS);
        if (gx >= cells_in_use(grid_w, MAX_GRID_W) || gz >= cells_in_use(grid_h, MAX_GRID_H))
            return 1'b0;
        x = gx[XW-1:0];
        z = gz[ZW-1:0];
        u = tx[FRAC_BITS-1:0];
        v = tz[FRAC_BITS-1:0];
        return 1'b1;
    endfunction

    // applies one accepted item: a load updates the grid, a query adds an answer
    task automatic absorb_item(input t_grid_item it);
        logic [2*SAMPLE_W:0] prod;
        logic [XW-1:0] x;
        logic [ZW-1:0] z;
        logic [FRAC_BITS-1:0] u;
        logic [FRAC_BITS-1:0] v;
        int xi, zi, ui, vi, acc;
        t_height_answer ans;
        if (it.op == OP_LOAD) begin
            // gain rounded half up to Q8.8, then offset, saturated
            prod = it.sample * gain + 33'd32768;
            shadow_heights[it.cell_index] = sat16(int'(prod[2*SAMPLE_W:16]) + int'(base));
        end else begin
            if (locate(it.qx, it.qz, x, z, u, v)) begin
                xi = x;
                zi = z;
                ui = u;
                vi = v;
                // lower triangle when u + v stays within one unit
                if (ui + vi <= UNIT)
                    acc = (UNIT - ui - vi) * stored_at(xi, zi)
                        + ui * stored_at(xi + 1, zi)
                        + vi * stored_at(xi, zi + 1);
                else
                    acc = (UNIT - vi) * stored_at(xi + 1, zi)
                        + (ui + vi - UNIT) * stored_at(xi + 1, zi + 1)
                        + (UNIT - ui) * stored_at(xi, zi + 1);
                ans.height   = sat16((acc + UNIT / 2) >>> FRAC_BITS);
                ans.in_range = 1'b1;
            end else begin
                ans.height   = '0;
                ans.in_range = 1'b0;
            end
            pending_answers = {pending_answers, ans};
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_frac();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return UNIT - 1;
            default: return $urandom_range(0, UNIT - 1);
        endcase
    endfunction

    task automatic queue_load(input int a, input logic [SAMPLE_W-1:0] s);
        t_grid_item it;
        it.op         = OP_LOAD;
        it.cell_index = IDX_W'(a);
        it.sample     = s;
        it.qx         = COORD_W'($urandom);
        it.qz         = COORD_W'($urandom);
        pending_items = {pending_items, it};
        cell_loaded[a] = 1'b1;
        queued_count++;
    endtask

    // a query in range first gets any unloaded corner of its cell loaded
    task automatic queue_query(input logic signed [COORD_W-1:0] qx,
                               input logic signed [COORD_W-1:0] qz);
        t_grid_item it;
        logic [XW-1:0] x;
        logic [ZW-1:0] z;
        logic [FRAC_BITS-1:0] u;
        logic [FRAC_BITS-1:0] v;
        int a;
        if (locate(qx, qz, x, z, u, v)) begin
            for (int dz = 0; dz < 2; dz++) begin
                for (int dx = 0; dx < 2; dx++) begin
                    a = (int'(z) + dz) * MAX_GRID_W + int'(x) + dx;
                    if (!cell_loaded[a]) queue_load(a, SAMPLE_W'($urandom));
                end
            end
        end
        it.op         = OP_QUERY;
        it.cell_index = IDX_W'($urandom);
        it.sample     = SAMPLE_W'($urandom);
        it.qx         = qx;
        it.qz         = qz;
        pending_items = {pending_items, it};
        queued_count++;
    endtask

    // query at a point given relative to the grid origin
    task automatic queue_offset_query(input int tx, input int tz);
        queue_query(COORD_W'(int'(org_x) + tx), COORD_W'(int'(org_z) + tz));
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ORIGIN_X:      org_x  = data;
            CFG_ORIGIN_Z:      org_z  = data;
            CFG_GRID_WIDTH:    grid_w = data[DIM_W-1:0];
            CFG_GRID_HEIGHT:   grid_h = data[DIM_W-1:0];
            CFG_HEIGHT_SCALE:  gain   = data[SCALE_W-1:0];
            CFG_HEIGHT_OFFSET: base   = data[HGT_W-1:0];
            default: ;
        endcase
    endtask

    // writes all six registers, with junk above the narrow fields
    task automatic program_grid(input int ox, input int oz, input int w, input int h,
                                input int g, input int b);
        logic [CFG_DATA_W-1:0] filler;
        filler = CFG_DATA_W'($urandom);
        set_reg(CFG_ORIGIN_X, CFG_DATA_W'(ox));
        set_reg(CFG_ORIGIN_Z, CFG_DATA_W'(oz));
        set_reg(CFG_GRID_WIDTH, {filler[CFG_DATA_W-1:DIM_W], DIM_W'(w)});
        set_reg(CFG_GRID_HEIGHT, {filler[DIM_W +: CFG_DATA_W-DIM_W], DIM_W'(h)});
        set_reg(CFG_HEIGHT_SCALE, {filler[CFG_DATA_W-1:SCALE_W], SCALE_W'(g)});
        set_reg(CFG_HEIGHT_OFFSET, {filler[SCALE_W +: CFG_DATA_W-HGT_W], HGT_W'(b)});
    endtask

    // waits until every item is taken and every height is back
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly queries on a small hot window, plus edge points, noise and loads
    task automatic random_traffic(input int count);
        int stop_at, nx, nz, hot_x, hot_z, gx, gz, u, v, r, tx_in, tz_in;
        nx = cells_in_use(grid_w, MAX_GRID_W);
        nz = cells_in_use(grid_h, MAX_GRID_H);
        hot_x = (nx > 0) ? $urandom_range(0, nx - 1) : 0;
        hot_z = (nz > 0) ? $urandom_range(0, nz - 1) : 0;
        stop_at = queued_count + count;
        while (queued_count < stop_at) begin
            r = $urandom_range(0, 99);
            tx_in = (nx > 0) ? $urandom_range(0, nx * UNIT - 1) : 0;
            tz_in = (nz > 0) ? $urandom_range(0, nz * UNIT - 1) : 0;
            if (r < 55 && nx > 0 && nz > 0) begin
                if ($urandom_range(0, 4) != 0) begin
                    gx = hot_x + $urandom_range(0, 5);
                    gz = hot_z + $urandom_range(0, 5);
                    if (gx > nx - 1) gx = nx - 1;
                    if (gz > nz - 1) gz = nz - 1;
                end else begin
                    gx = $urandom_range(0, nx - 1);
                    gz = $urandom_range(0, nz - 1);
                end
                // now and then sit on the diagonal between the two triangles
                if ($urandom_range(0, 9) == 0) begin
                    u = $urandom_range(1, UNIT - 1);
                    v = UNIT - u + $urandom_range(0, 1);
                    if (v > UNIT - 1) v = UNIT - 1;
                end else begin
                    u = pick_frac();
                    v = pick_frac();
                end
                queue_offset_query(gx * UNIT + u, gz * UNIT + v);
            end else if (r < 70) begin
                // just outside one of the four borders
                case ($urandom_range(0, 3))
                    0: queue_offset_query(-int'($urandom_range(1, 2 * UNIT)), tz_in);
                    1: queue_offset_query(nx * UNIT + int'($urandom_range(0, UNIT - 1)), tz_in);
                    2: queue_offset_query(tx_in, -int'($urandom_range(1, 2 * UNIT)));
                    default: queue_offset_query(tx_in, nz * UNIT + int'($urandom_range(0, UNIT - 1)));
                endcase
            end else if (r < 80) begin
                queue_query(COORD_W'($urandom), COORD_W'($urandom));
            end else begin
                queue_load($urandom_range(0, STORE_DEPTH - 1), SAMPLE_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // slave-side driver: offers queued items, predicts each transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : item_driver
        bit slot_free;
        if (i_rst_n) begin
            slot_free = !s_tvalid;
            if (s_tvalid && s_axis_tready) begin
                absorb_item(offered);
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (send_gap != 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_items.size() != 0) begin
                    offered  <= pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap <= send_idle_on ? pick_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // master-side monitor: checks heights in order and drives tready
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_height_answer want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (pending_answers.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("unexpected result: height %0d in_range %0b",
                                 $signed(m_axis_tdata[HGT_W-1:0]), m_axis_tuser[0]);
                end else begin
                    want = pending_answers.pop_front();
                    if (m_axis_tdata[HGT_W-1:0] !== want.height ||
                        m_axis_tuser[0] !== want.in_range) begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("mismatch: height exp %0d got %0d, in_range exp %0b got %0b",
                                     want.height, $signed(m_axis_tdata[HGT_W-1:0]),
                                     want.in_range, m_axis_tuser[0]);
                    end
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (recv_gap != 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                recv_gap <= pick_gap();
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one long hold on the result side while plenty of items are still queued
    always @(posedge i_clk) begin
        if (!hold_done && results_seen >= 50 && pending_items.size() >= 40) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[heightmap_barycentric_sampler_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : test_sequence
        int ph;
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners of the first cell and every triangle case at reset settings
        queue_load(0, 16'h0000);
        queue_load(1, 16'hFFFF);
        queue_load(MAX_GRID_W, 16'h8000);
        queue_load(MAX_GRID_W + 1, 16'h1234);
        queue_offset_query(0, 0);
        queue_offset_query(UNIT - 1, 0);
        queue_offset_query(0, UNIT - 1);
        queue_offset_query(UNIT / 2, UNIT / 2);
        queue_offset_query(UNIT / 2 + 1, UNIT / 2);
        queue_offset_query(UNIT - 1, UNIT - 1);
        // outside: left of origin, most negative and most positive points
        queue_offset_query(-1, 0);
        queue_query(COORD_W'(-524288), '0);
        queue_query(COORD_W'(524287), COORD_W'(524287));
        // last cell of the grid and the point just past it
        queue_load(62 * MAX_GRID_W + 62, 16'h00FF);
        queue_load(62 * MAX_GRID_W + 63, 16'h7F00);
        queue_load(63 * MAX_GRID_W + 62, 16'hABCD);
        queue_load(STORE_DEPTH - 1, 16'hFFFF);
        queue_offset_query(62 * UNIT + 200, 62 * UNIT + 10);
        queue_offset_query(63 * UNIT, 62 * UNIT);
        wait_idle();

        // most negative origin, full gain and offset: stored heights saturate
        program_grid(-524288, -524288, 64, 64, 65535, 32767);
        queue_load(0, 16'hFFFF);
        queue_load(1, 16'hFFFF);
        queue_load(MAX_GRID_W, 16'hFFFF);
        queue_load(MAX_GRID_W + 1, 16'hFFFF);
        queue_offset_query(100, 50);
        queue_offset_query(200, 180);
        wait_idle();

        for (ph = 0; ph < 8; ph++) begin
            send_idle_on = (ph % 3 != 2);
            recv_idle_on = (ph % 4 != 1);
            case (ph)
                0: begin
                    program_grid(int'($urandom_range(0, 4000)) - 2000,
                                 int'($urandom_range(0, 4000)) - 2000, 64, 64, 6554, 0);
                    n = 300;
                end
                1: begin
                    // smallest grid: a single cell
                    program_grid(int'($urandom_range(0, 400000)) - 200000,
                                 int'($urandom_range(0, 400000)) - 200000, 2, 2,
                                 $urandom_range(0, 65535), int'($urandom_range(0, 65535)) - 32768);
                    n = 150;
                end
                2: begin
                    // width too small, plus writes to undecoded indexes
                    program_grid(int'($urandom_range(0, 4000)) - 2000, 0, 1,
                                 $urandom_range(2, 64), $urandom_range(0, 65535),
                                 int'($urandom_range(0, 65535)) - 32768);
                    set_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
                    set_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
                    n = 120;
                end
                3: begin
                    // sizes above the maximum are clamped
                    program_grid(-524288, int'($urandom_range(0, 8000)) - 4000, 127, 65,
                                 65535, 32767);
                    n = 250;
                end
                4: begin
                    program_grid(524287, -524288, $urandom_range(2, 64), $urandom_range(2, 64),
                                 0, -32768);
                    n = 150;
                end
                5: begin
                    program_grid(int'($urandom_range(0, 4000)) - 2000,
                                 int'($urandom_range(0, 4000)) - 2000, 0, 0,
                                 $urandom_range(0, 65535), int'($urandom_range(0, 65535)) - 32768);
                    n = 80;
                end
                6: begin
                    program_grid(int'($urandom_range(0, 1048575)) - 524288,
                                 int'($urandom_range(0, 1048575)) - 524288,
                                 $urandom_range(2, 64), $urandom_range(2, 64),
                                 $urandom_range(0, 65535), int'($urandom_range(0, 65535)) - 32768);
                    n = 400;
                end
                default: begin
                    program_grid(int'($urandom_range(0, 4000)) - 2000,
                                 int'($urandom_range(0, 4000)) - 2000,
                                 $urandom_range(2, 10), $urandom_range(2, 10),
                                 $urandom_range(0, 65535), int'($urandom_range(0, 65535)) - 32768);
                    n = 300;
                end
            endcase
            random_traffic(n);
            wait_idle();
        end

        // anything still owed counts against the run
        error_count += pending_answers.size();
        if (error_count == 0)
            $display("[heightmap_barycentric_sampler_top] OK");
        else
            $display("[heightmap_barycentric_sampler_top] ERROR");
        $finish;
    end

endmodule
